@@ rtl/binomial_mod_prime_engine_defines.svh @@
// Assertion macros shared by the engine's RTL files.
`ifndef BINOMIAL_MOD_PRIME_ENGINE_DEFINES_SVH
`define BINOMIAL_MOD_PRIME_ENGINE_DEFINES_SVH

// Clocked assertion that is switched off while reset is held.
`define BMPE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define BMPE_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/bmpe_pkg.sv @@
// Package with the constants and codes of the binomial modulo prime engine.
package bmpe_pkg;

    // Table storage.
    localparam int TableDepth = 1024;
    localparam int AddrW      = $clog2(TableDepth);
    localparam int SizeW      = AddrW + 1;

    // Operand widths.
    localparam int WordW = 32;
    localparam int ArgW  = 64;

    // Reset values of the configuration registers.
    localparam logic [WordW-1:0] ModulusReset   = 32'd998244353;
    localparam logic [SizeW-1:0] TableSizeReset = SizeW'(TableDepth);

    // Configuration register indexes.
    localparam logic CfgModulus   = 1'b0;
    localparam logic CfgTableSize = 1'b1;

    // Opcodes.
    localparam logic [2:0] OpBuild   = 3'd0;
    localparam logic [2:0] OpPower   = 3'd1;
    localparam logic [2:0] OpInverse = 3'd2;
    localparam logic [2:0] OpArrange = 3'd3;
    localparam logic [2:0] OpBinom   = 3'd4;

    // Status codes.
    localparam logic [1:0] StOk       = 2'd0;
    localparam logic [1:0] StRange    = 2'd1;
    localparam logic [1:0] StNotBuilt = 2'd2;
    localparam logic [1:0] StNegExp   = 2'd3;

    // Request to the shared modular multiplier.
    typedef struct packed {
        logic             start;
        logic [WordW-1:0] a;
        logic [WordW-1:0] b;
    } t_mm_req;

endpackage

@@ rtl/binomial_mod_prime_engine.sv @@
// Binomial modulo prime engine: a request is taken when i_start is high and o_busy is low.
// Every request, valid or not, gives exactly one result, shown for one cycle with o_valid;
// the receiver cannot stall it. All arithmetic runs through one bit-serial modular
// multiplier, so the time an operation takes is set by how many products it needs.
// Arrangements need two products and binomial queries three; power reduces the base,
// then squares once per exponent bit up to the top set bit and multiplies once per set
// bit; inverse is a power with exponent modulus - 2. Build needs about two products per
// table entry plus one inverse.
module binomial_mod_prime_engine
    import bmpe_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    output logic             o_busy,
    input  logic [2:0]       i_opcode,
    input  logic [ArgW-1:0]  i_n,
    input  logic [ArgW-1:0]  i_k,
    input  logic [WordW-1:0] i_base,
    input  logic             i_cfg_we,
    input  logic             i_cfg_idx,
    input  logic [WordW-1:0] i_cfg_data,
    output logic             o_valid,
    output logic [WordW-1:0] o_value,
    output logic [1:0]       o_status
);
`include "binomial_mod_prime_engine_defines.svh"

    // Sequencer states.
    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_DEC     = 4'd1;
    localparam logic [3:0] S_PW_RED  = 4'd2;
    localparam logic [3:0] S_PW_CHK  = 4'd3;
    localparam logic [3:0] S_PW_MUL  = 4'd4;
    localparam logic [3:0] S_PW_SQ   = 4'd5;
    localparam logic [3:0] S_B_FACT  = 4'd6;
    localparam logic [3:0] S_B_IF0   = 4'd7;
    localparam logic [3:0] S_B_IFACT = 4'd8;
    localparam logic [3:0] S_Q_RD    = 4'd9;
    localparam logic [3:0] S_Q_KICK  = 4'd10;
    localparam logic [3:0] S_Q_M1    = 4'd11;
    localparam logic [3:0] S_Q_M2    = 4'd12;
    localparam logic [3:0] S_Q_M3    = 4'd13;

    logic [3:0]       r_state, n_state;
    logic [WordW-1:0] r_modulus;
    logic [SizeW-1:0] r_table_size;
    logic [2:0]       r_op, n_op;
    logic [ArgW-1:0]  r_n, n_n;
    logic [ArgW-1:0]  r_k, n_k;
    logic [WordW-1:0] r_base, n_base;
    logic [ArgW-1:0]  r_e, n_e;
    logic [WordW-1:0] r_x, n_x;
    logic [WordW-1:0] r_r, n_r;
    logic [SizeW-1:0] r_idx, n_idx;
    logic [SizeW-1:0] r_size, n_size;
    logic             r_pw_build, n_pw_build;
    logic             r_built, n_built;
    logic [SizeW-1:0] r_built_size, n_built_size;
    logic [AddrW-1:0] r_fa, n_fa;
    logic [AddrW-1:0] r_ia, n_ia;
    logic             r_valid, n_valid;
    logic [WordW-1:0] r_value, n_value;
    logic [1:0]       r_status, n_status;

    // Table memories with registered reads.
    logic [WordW-1:0] r_fact_mem [TableDepth];
    logic [WordW-1:0] r_ifact_mem [TableDepth];
    logic [WordW-1:0] r_rd_f;
    logic [WordW-1:0] r_rd_i;
    logic             w_f_we, w_i_we;
    logic [AddrW-1:0] w_f_addr, w_i_addr;
    logic [WordW-1:0] w_f_wd, w_i_wd;

    t_mm_req          w_mm_req;
    logic             w_mm_done;
    logic [WordW-1:0] w_mm_res;

    logic [WordW-1:0] w_eff_mod;
    logic [WordW-1:0] w_one;
    logic [ArgW-1:0]  w_exp_inv;
    logic [SizeW-1:0] w_size_clamp;
    logic [ArgW-1:0]  w_diff;

    // Effective modulus: below two the engine works modulo one.
    always_comb begin
        w_eff_mod = (r_modulus < WordW'(2)) ? WordW'(1) : r_modulus;
        w_one     = (w_eff_mod == WordW'(1)) ? '0 : WordW'(1);
        w_exp_inv = (r_modulus < WordW'(2)) ? '0 : ArgW'(r_modulus - WordW'(2));
        if (r_table_size < SizeW'(2)) begin
            w_size_clamp = SizeW'(2);
        end else if (r_table_size > SizeW'(TableDepth)) begin
            w_size_clamp = SizeW'(TableDepth);
        end else begin
            w_size_clamp = r_table_size;
        end
        w_diff = r_n - r_k;
    end

    // Shared modular multiplier.
    bmpe_mulmod u_mulmod (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_mm_req),
        .i_mod   (w_eff_mod),
        .o_done  (w_mm_done),
        .o_res   (w_mm_res)
    );

    // Sequencer.
    always_comb begin
        n_state      = r_state;
        n_op         = r_op;
        n_n          = r_n;
        n_k          = r_k;
        n_base       = r_base;
        n_e          = r_e;
        n_x          = r_x;
        n_r          = r_r;
        n_idx        = r_idx;
        n_size       = r_size;
        n_pw_build   = r_pw_build;
        n_built      = r_built;
        n_built_size = r_built_size;
        n_fa         = r_fa;
        n_ia         = r_ia;
        n_valid      = 1'b0;
        n_value      = r_value;
        n_status     = r_status;
        w_mm_req     = '0;
        w_f_we       = 1'b0;
        w_f_addr     = r_idx[AddrW-1:0];
        w_f_wd       = w_mm_res;
        w_i_we       = 1'b0;
        w_i_addr     = r_idx[AddrW-1:0];
        w_i_wd       = w_mm_res;

        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_op    = i_opcode;
                    n_n     = i_n;
                    n_k     = i_k;
                    n_base  = i_base;
                    n_state = S_DEC;
                end
            end

            S_DEC: begin
                n_value  = '0;
                n_status = StOk;
                n_r      = w_one;
                case (r_op)
                    OpBuild: begin
                        // Factorial of zero, then the first product.
                        w_f_we         = 1'b1;
                        w_f_addr       = '0;
                        w_f_wd         = w_one;
                        n_size         = w_size_clamp;
                        n_idx          = SizeW'(1);
                        w_mm_req.start = 1'b1;
                        w_mm_req.a     = w_one;
                        w_mm_req.b     = WordW'(1);
                        n_state        = S_B_FACT;
                    end
                    OpPower: begin
                        if (r_k[ArgW-1]) begin
                            n_status = StNegExp;
                            n_valid  = 1'b1;
                            n_state  = S_IDLE;
                        end else begin
                            n_e            = r_k;
                            n_pw_build     = 1'b0;
                            w_mm_req.start = 1'b1;
                            w_mm_req.a     = w_one;
                            w_mm_req.b     = r_base;
                            n_state        = S_PW_RED;
                        end
                    end
                    OpInverse: begin
                        if (r_modulus < WordW'(2)) begin
                            n_valid = 1'b1;
                            n_state = S_IDLE;
                        end else begin
                            n_e            = w_exp_inv;
                            n_pw_build     = 1'b0;
                            w_mm_req.start = 1'b1;
                            w_mm_req.a     = w_one;
                            w_mm_req.b     = r_base;
                            n_state        = S_PW_RED;
                        end
                    end
                    OpArrange, OpBinom: begin
                        if (!r_built) begin
                            n_status = StNotBuilt;
                            n_valid  = 1'b1;
                            n_state  = S_IDLE;
                        end else if (!r_n[ArgW-1] && r_n >= ArgW'(r_built_size)) begin
                            n_status = StRange;
                            n_valid  = 1'b1;
                            n_state  = S_IDLE;
                        end else if (r_n[ArgW-1] || r_k[ArgW-1] || r_k > r_n) begin
                            n_valid = 1'b1;
                            n_state = S_IDLE;
                        end else begin
                            n_fa    = r_n[AddrW-1:0];
                            n_ia    = w_diff[AddrW-1:0];
                            n_state = S_Q_RD;
                        end
                    end
                    default: begin
                        n_valid = 1'b1;
                        n_state = S_IDLE;
                    end
                endcase
            end

            // Power: base reduced, then square-and-multiply from the low bit.
            S_PW_RED: begin
                if (w_mm_done) begin
                    n_x     = w_mm_res;
                    n_state = S_PW_CHK;
                end
            end

            S_PW_CHK: begin
                if (r_e == '0) begin
                    if (r_pw_build) begin
                        w_i_we   = 1'b1;
                        w_i_addr = AddrW'(r_size - SizeW'(1));
                        w_i_wd   = r_r;
                        n_state  = S_B_IF0;
                    end else begin
                        n_value = r_r;
                        n_valid = 1'b1;
                        n_state = S_IDLE;
                    end
                end else if (r_e[0]) begin
                    w_mm_req.start = 1'b1;
                    w_mm_req.a     = r_r;
                    w_mm_req.b     = r_x;
                    n_state        = S_PW_MUL;
                end else begin
                    w_mm_req.start = 1'b1;
                    w_mm_req.a     = r_x;
                    w_mm_req.b     = r_x;
                    n_state        = S_PW_SQ;
                end
            end

            S_PW_MUL: begin
                if (w_mm_done) begin
                    n_r            = w_mm_res;
                    w_mm_req.start = 1'b1;
                    w_mm_req.a     = r_x;
                    w_mm_req.b     = r_x;
                    n_state        = S_PW_SQ;
                end
            end

            S_PW_SQ: begin
                if (w_mm_done) begin
                    n_x     = w_mm_res;
                    n_e     = {1'b0, r_e[ArgW-1:1]};
                    n_state = S_PW_CHK;
                end
            end

            // Build: factorials upwards, carried in the multiplier result.
            S_B_FACT: begin
                if (w_mm_done) begin
                    w_f_we = 1'b1;
                    if (r_idx + SizeW'(1) < r_size) begin
                        n_idx          = r_idx + SizeW'(1);
                        w_mm_req.start = 1'b1;
                        w_mm_req.a     = w_mm_res;
                        w_mm_req.b     = WordW'(r_idx + SizeW'(1));
                    end else begin
                        n_x        = w_mm_res;
                        n_r        = w_one;
                        n_e        = w_exp_inv;
                        n_pw_build = 1'b1;
                        n_state    = S_PW_CHK;
                    end
                end
            end

            S_B_IF0: begin
                w_i_we   = 1'b1;
                w_i_addr = '0;
                w_i_wd   = w_one;
                if (r_size > SizeW'(2)) begin
                    n_idx          = r_size - SizeW'(2);
                    w_mm_req.start = 1'b1;
                    w_mm_req.a     = r_r;
                    w_mm_req.b     = WordW'(r_size - SizeW'(1));
                    n_state        = S_B_IFACT;
                end else begin
                    n_built      = 1'b1;
                    n_built_size = r_size;
                    n_valid      = 1'b1;
                    n_state      = S_IDLE;
                end
            end

            // Build: inverse factorials downwards.
            S_B_IFACT: begin
                if (w_mm_done) begin
                    w_i_we = 1'b1;
                    if (r_idx > SizeW'(1)) begin
                        n_idx          = r_idx - SizeW'(1);
                        w_mm_req.start = 1'b1;
                        w_mm_req.a     = w_mm_res;
                        w_mm_req.b     = WordW'(r_idx);
                    end else begin
                        n_built      = 1'b1;
                        n_built_size = r_size;
                        n_valid      = 1'b1;
                        n_state      = S_IDLE;
                    end
                end
            end

            // Query: table reads, then up to three products.
            S_Q_RD: begin
                n_state = S_Q_KICK;
            end

            S_Q_KICK: begin
                w_mm_req.start = 1'b1;
                w_mm_req.a     = w_one;
                w_mm_req.b     = r_rd_f;
                n_state        = S_Q_M1;
            end

            S_Q_M1: begin
                if (w_mm_done) begin
                    n_ia           = r_k[AddrW-1:0];
                    w_mm_req.start = 1'b1;
                    w_mm_req.a     = w_mm_res;
                    w_mm_req.b     = r_rd_i;
                    n_state        = S_Q_M2;
                end
            end

            S_Q_M2: begin
                if (w_mm_done) begin
                    if (r_op == OpBinom) begin
                        w_mm_req.start = 1'b1;
                        w_mm_req.a     = w_mm_res;
                        w_mm_req.b     = r_rd_i;
                        n_state        = S_Q_M3;
                    end else begin
                        n_value = w_mm_res;
                        n_valid = 1'b1;
                        n_state = S_IDLE;
                    end
                end
            end

            S_Q_M3: begin
                if (w_mm_done) begin
                    n_value = w_mm_res;
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers and configuration.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_valid      <= 1'b0;
            r_built      <= 1'b0;
            r_built_size <= '0;
            r_modulus    <= ModulusReset;
            r_table_size <= TableSizeReset;
        end else begin
            r_state      <= n_state;
            r_valid      <= n_valid;
            r_built      <= n_built;
            r_built_size <= n_built_size;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CfgModulus:   r_modulus    <= i_cfg_data;
                    CfgTableSize: r_table_size <= i_cfg_data[SizeW-1:0];
                    default:      r_modulus    <= r_modulus;
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_op       <= n_op;
        r_n        <= n_n;
        r_k        <= n_k;
        r_base     <= n_base;
        r_e        <= n_e;
        r_x        <= n_x;
        r_r        <= n_r;
        r_idx      <= n_idx;
        r_size     <= n_size;
        r_pw_build <= n_pw_build;
        r_fa       <= n_fa;
        r_ia       <= n_ia;
        r_value    <= n_value;
        r_status   <= n_status;
    end

    // Table memories.
    always_ff @(posedge i_clk) begin
        if (w_f_we) begin
            r_fact_mem[w_f_addr] <= w_f_wd;
        end
        r_rd_f <= r_fact_mem[r_fa];
    end

    always_ff @(posedge i_clk) begin
        if (w_i_we) begin
            r_ifact_mem[w_i_addr] <= w_i_wd;
        end
        r_rd_i <= r_ifact_mem[r_ia];
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_valid  = r_valid;
    assign o_value  = r_value;
    assign o_status = r_status;

    `BMPE_ASSERT(a_valid_idle, i_clk, i_rst_n, r_valid |-> (r_state == S_IDLE), "result while busy")
    `BMPE_ASSERT(a_accept_dec, i_clk, i_rst_n, (i_start && r_state == S_IDLE) |=> (r_state == S_DEC), "request not decoded")
    `BMPE_ASSERT(a_err_zero, i_clk, i_rst_n, (r_valid && r_status != StOk) |-> (r_value == '0), "error with non-zero value")
    `BMPE_ASSERT(a_done_wait, i_clk, i_rst_n, w_mm_done |-> (r_state == S_PW_RED || r_state == S_PW_MUL || r_state == S_PW_SQ || r_state == S_B_FACT || r_state == S_B_IFACT || r_state == S_Q_M1 || r_state == S_Q_M2 || r_state == S_Q_M3), "product in wrong state")
    `BMPE_ASSERT_ALWAYS(a_rst_idle, i_clk, !i_rst_n |=> (r_state == S_IDLE && !r_valid), "reset not idle")

endmodule

@@ rtl/bmpe_mulmod.sv @@
// Bit-serial modular multiplier: one bit of the multiplier per cycle.
module bmpe_mulmod
    import bmpe_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_mm_req          i_req,
    input  logic [WordW-1:0] i_mod,
    output logic             o_done,
    output logic [WordW-1:0] o_res
);
`include "binomial_mod_prime_engine_defines.svh"

    localparam int CntW = $clog2(WordW + 1);

    logic [WordW-1:0] r_acc, n_acc;
    logic [WordW-1:0] r_a;
    logic [WordW-1:0] r_b;
    logic [CntW-1:0]  r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [WordW:0]   w_dbl;
    logic [WordW-1:0] w_red;
    logic [WordW:0]   w_sum;

    // One step: double, reduce, add the partial product, reduce again.
    // Operand a is below the modulus, so each reduction needs one subtract.
    always_comb begin
        w_dbl = {r_acc, 1'b0};
        if (w_dbl >= {1'b0, i_mod}) begin
            w_dbl = w_dbl - {1'b0, i_mod};
        end
        w_red = w_dbl[WordW-1:0];
        w_sum = {1'b0, w_red} + (r_b[WordW-1] ? {1'b0, r_a} : '0);
        if (w_sum >= {1'b0, i_mod}) begin
            w_sum = w_sum - {1'b0, i_mod};
        end
        n_acc = w_sum[WordW-1:0];
    end

    // Control of the iteration count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CntW'(WordW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CntW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Operand and accumulator registers.
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_acc <= '0;
            r_a   <= i_req.a;
            r_b   <= i_req.b;
        end else if (r_busy) begin
            r_acc <= n_acc;
            r_b   <= {r_b[WordW-2:0], 1'b0};
        end
    end

    assign o_done = r_done;
    assign o_res  = r_acc;

    `BMPE_ASSERT(a_no_start_busy, i_clk, i_rst_n, i_req.start |-> !r_busy, "request while busy")
    `BMPE_ASSERT(a_done_idle, i_clk, i_rst_n, r_done |-> !r_busy, "done while busy")
    `BMPE_ASSERT(a_res_reduced, i_clk, i_rst_n, r_done |-> (r_acc < i_mod || i_mod < 32'd2), "result not reduced")

endmodule

@@ bench/binomial_mod_prime_engine_test.sv @@
// Self-checking testbench for the binomial modulo prime engine.
module binomial_mod_prime_engine_test;
    import bmpe_pkg::*;

    localparam int WatchLimit = 400000;

    typedef struct {
        logic [2:0]       op;
        logic [ArgW-1:0]  n;
        logic [ArgW-1:0]  k;
        logic [WordW-1:0] base;
    } t_request;

    typedef struct {
        logic [WordW-1:0] value;
        logic [1:0]       status;
    } t_answer;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             i_start = 1'b0;
    logic             o_busy;
    logic [2:0]       i_opcode = '0;
    logic [ArgW-1:0]  i_n = '0;
    logic [ArgW-1:0]  i_k = '0;
    logic [WordW-1:0] i_base = '0;
    logic             i_cfg_we = 1'b0;
    logic             i_cfg_idx = 1'b0;
    logic [WordW-1:0] i_cfg_data = '0;
    logic             o_valid;
    logic [WordW-1:0] o_value;
    logic [1:0]       o_status;

    binomial_mod_prime_engine i_dut (.*);

    always #1 i_clk = ~i_clk;

    // Own copy of the engine state.
    logic [WordW-1:0] fact_tab [TableDepth];
    logic [WordW-1:0] inv_fact_tab [TableDepth];
    logic             tabs_ready = 1'b0;
    int unsigned      tabs_size = 0;
    logic [WordW-1:0] cur_mod = ModulusReset;
    logic [10:0]      cur_size = TableSizeReset;

    t_request pending_q[$];
    t_answer  answer_q[$];
    int       err_cnt = 0;
    int       idle_cnt = 0;

    function automatic longint unsigned mod_eff();
        return (cur_mod < 2) ? 64'd1 : 64'(cur_mod);
    endfunction

    function automatic logic [WordW-1:0] mul_mod(longint unsigned a, longint unsigned b);
        return WordW'((a * b) % mod_eff());
    endfunction

    function automatic logic [WordW-1:0] pow_mod(longint unsigned x, longint unsigned e);
        longint unsigned m;
        longint unsigned r;
        m = mod_eff();
        r = 64'd1 % m;
        x = x % m;
        while (e != 0) begin
            if (e[0]) r = mul_mod(r, x);
            x = mul_mod(x, x);
            e = e >> 1;
        end
        return WordW'(r);
    endfunction

    // Fill both tables the way the engine does for the current size.
    function automatic void build_tabs();
        int unsigned      sz;
        longint unsigned  m;
        int               i;
        sz = cur_size;
        m = mod_eff();
        if (sz < 2) sz = 2;
        if (sz > TableDepth) sz = TableDepth;
        fact_tab[0] = WordW'(64'd1 % m);
        for (i = 1; i < sz; i++) fact_tab[i] = mul_mod(fact_tab[i-1], i);
        inv_fact_tab[0] = WordW'(64'd1 % m);
        inv_fact_tab[sz-1] = pow_mod(fact_tab[sz-1], (m < 2) ? m : m - 2);
        for (i = sz - 2; i >= 1; i--) inv_fact_tab[i] = mul_mod(inv_fact_tab[i+1], i + 1);
        tabs_size = sz;
        tabs_ready = 1'b1;
    endfunction

    // Expected answer for one request, updating the state for a build.
    function automatic t_answer combinatoric_answer(t_request r);
        t_answer a;
        a.value = '0;
        a.status = StOk;
        case (r.op)
            OpBuild: build_tabs();
            OpPower: begin
                if (r.k[ArgW-1]) a.status = StNegExp;
                else a.value = pow_mod(r.base, r.k);
            end
            OpInverse: a.value = (mod_eff() < 2) ? '0 : pow_mod(r.base, mod_eff() - 2);
            OpArrange, OpBinom: begin
                if (!tabs_ready) begin
                    a.status = StNotBuilt;
                end else if (!r.n[ArgW-1] && r.n >= tabs_size) begin
                    a.status = StRange;
                end else if (r.n[ArgW-1] || r.k[ArgW-1] || r.k > r.n) begin
                    a.value = '0;
                end else begin
                    a.value = mul_mod(fact_tab[r.n[9:0]], inv_fact_tab[r.n[9:0] - r.k[9:0]]);
                    if (r.op == OpBinom) a.value = mul_mod(a.value, inv_fact_tab[r.k[9:0]]);
                end
            end
            default: ;
        endcase
        return a;
    endfunction

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
        err_cnt++;
    endtask

    // Driver: requests go out in bursts with random gaps in between.
    int gap_left = 0;
    int burst_left = 0;
    always @(posedge i_clk) begin
        logic     taken;
        logic     hold;
        logic     drive;
        t_request r;
        taken = i_rst_n && i_start && !o_busy;
        hold = i_start && !taken;
        drive = hold;
        if (taken) begin
            answer_q.push_back(combinatoric_answer(pending_q.pop_front()));
        end
        if (!drive && i_rst_n && pending_q.size() > 0) begin
            if (gap_left > 0) begin
                gap_left--;
            end else begin
                drive = 1'b1;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 30);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                end
            end
        end
        if (drive && !hold) begin
            r = pending_q[0];
            i_opcode <= r.op;
            i_n <= r.n;
            i_k <= r.k;
            i_base <= r.base;
        end
        i_start <= drive;
    end

    // Monitor: every strobed result is checked against the oldest expectation.
    always @(posedge i_clk) begin
        t_answer a;
        if (i_rst_n && o_valid) begin
            if (answer_q.size() == 0) begin
                report("unexpected result", o_value, 0);
            end else begin
                a = answer_q.pop_front();
                if (o_value !== a.value) report("value", o_value, a.value);
                if (o_status !== a.status) report("status", o_status, a.status);
            end
        end
    end

    // Watchdog on cycles with no request taken and no result.
    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_valid) idle_cnt <= 0;
        else idle_cnt <= idle_cnt + 1;
        if (idle_cnt > WatchLimit) begin
            $display("binomial_mod_prime_engine_test: errors");
            $finish;
        end
    end

    function automatic t_request mk(logic [2:0] op, logic [63:0] n, logic [63:0] k,
                                    logic [31:0] base);
        t_request r;
        r.op = op;
        r.n = n;
        r.k = k;
        r.base = base;
        return r;
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Random argument near or inside the table range, sometimes anything at all.
    function automatic logic [63:0] rand_arg(int unsigned span);
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 7) return 64'($urandom_range(0, span + 2));
        if (sel < 8) return -64'($urandom_range(1, 5));
        return rand64();
    endfunction

    function automatic t_request rand_request(int unsigned span, bit cheap_build);
        int          sel;
        logic [63:0] n;
        logic [63:0] k;
        sel = $urandom_range(0, 99);
        n = rand_arg(span);
        k = ($urandom_range(0, 3) == 0) ? rand_arg(span) : 64'($urandom_range(0, n[9:0]));
        if (sel < 2 && cheap_build) return mk(OpBuild, n, k, $urandom());
        if (sel < 17) begin
            case ($urandom_range(0, 9))
                0: k = rand64();
                1: k = 64'($urandom());
                default: k = 64'($urandom_range(0, 1000));
            endcase
            return mk(OpPower, n, k, $urandom());
        end
        if (sel < 25) return mk(OpInverse, n, k, $urandom());
        if (sel < 28) return mk(3'($urandom_range(5, 7)), rand64(), rand64(), $urandom());
        return mk((sel < 60) ? OpArrange : OpBinom, n, k, $urandom());
    endfunction

    task automatic wait_drained();
        while (pending_q.size() > 0 || answer_q.size() > 0 || i_start) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [31:0] data);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CfgModulus) cur_mod = data;
        else cur_size = data[10:0];
        @(posedge i_clk);
    endtask

    initial begin
        logic [31:0] mod_list [8] = '{32'd2, 32'd4294967291, 32'd0, 32'd1,
                                      32'd4294967295, 32'd1000000007, 32'd13, 32'd65521};
        logic [31:0] size_list [8] = '{32'd2, 32'd37, 32'd0, 32'd2047,
                                       32'd1, 32'd64, 32'd20, 32'd100};
        int unsigned span;
        int          p;
        int          j;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: queries before build, corner operands, unused opcodes, full build.
        pending_q.push_back(mk(OpArrange, 5, 2, 0));
        pending_q.push_back(mk(OpBinom, 5, 2, 0));
        pending_q.push_back(mk(OpPower, 0, -64'sd1, 7));
        pending_q.push_back(mk(OpPower, 0, 0, 0));
        pending_q.push_back(mk(OpPower, 0, 64'h7fff_ffff_ffff_ffff, 32'hffff_ffff));
        pending_q.push_back(mk(OpPower, 0, 64'h8000_0000_0000_0000, 3));
        pending_q.push_back(mk(OpInverse, 0, 0, 0));
        pending_q.push_back(mk(OpInverse, 0, 0, 1));
        pending_q.push_back(mk(OpInverse, 0, 0, 32'hffff_ffff));
        pending_q.push_back(mk(3'd5, -64'sd1, -64'sd1, 32'hffff_ffff));
        pending_q.push_back(mk(3'd6, 0, 0, 0));
        pending_q.push_back(mk(3'd7, 1, 1, 1));
        pending_q.push_back(mk(OpBuild, 0, 0, 0));
        pending_q.push_back(mk(OpBinom, 1023, 0, 0));
        pending_q.push_back(mk(OpBinom, 1023, 1023, 0));
        pending_q.push_back(mk(OpBinom, 1023, 511, 0));
        pending_q.push_back(mk(OpArrange, 1023, 1023, 0));
        pending_q.push_back(mk(OpArrange, 1024, 0, 0));
        pending_q.push_back(mk(OpBinom, 64'h7fff_ffff_ffff_ffff, 0, 0));
        pending_q.push_back(mk(OpBinom, 64'h8000_0000_0000_0000, 0, 0));
        pending_q.push_back(mk(OpArrange, -64'sd1, 0, 0));
        pending_q.push_back(mk(OpBinom, 10, -64'sd1, 0));
        pending_q.push_back(mk(OpBinom, 10, 11, 0));
        pending_q.push_back(mk(OpArrange, 0, 0, 0));
        pending_q.push_back(mk(OpBinom, 10, 64'h7fff_ffff_ffff_ffff, 0));
        for (j = 0; j < 150; j++) pending_q.push_back(rand_request(1023, 1'b0));
        wait_drained();

        // Random phases over a spread of settings, with and without a fresh build.
        for (p = 0; p < 8; p++) begin
            write_reg(CfgModulus, mod_list[p]);
            write_reg(CfgTableSize, size_list[p]);
            span = (size_list[p] < 2) ? 2 : (size_list[p] > 1024) ? 1024 : size_list[p];
            if (p != 5) pending_q.push_back(mk(OpBuild, 0, 0, 0));
            else span = 1023;
            for (j = 0; j < 130; j++) pending_q.push_back(rand_request(span, span <= 128));
            wait_drained();
        end

        // Random modulus with the table size back at its reset value, no rebuild.
        write_reg(CfgModulus, $urandom());
        write_reg(CfgTableSize, TableSizeReset);
        for (j = 0; j < 40; j++) pending_q.push_back(rand_request(100, 1'b0));
        wait_drained();
        repeat (200) @(posedge i_clk);

        if (err_cnt == 0) $display("binomial_mod_prime_engine_test: clean");
        else $display("binomial_mod_prime_engine_test: errors");
        $finish;
    end

endmodule
